// ===== src/assert_macros.svh =====
// Assertion macros shared by the parser RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== src/sfp_pkg.sv =====
// Shared types, codes and CRC helper for the sensor frame parser.
`default_nettype none

package sfp_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// Result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_PASS    = 2'd1;
	localparam logic [1:0] KIND_FAIL    = 2'd2;

	// Config register indexes
	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_CRC_SEED    = 2'd2;
	localparam logic [1:0] REG_MAX_LENGTH  = 2'd3;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [31:0] CRC_SEED_RST    = 32'd1;
	localparam logic [15:0] MAX_LENGTH_RST  = 16'd9999;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [31:0] crc_seed;
		logic [15:0] max_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] bad_frames;
		logic [15:0] frame_length;
		logic [15:0] frame_id;
		logic [15:0] payload_index;
		logic [7:0]  payload_byte;
	} res_t;

	// Reflected CRC-32, one byte, bitwise.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/sfp_parser.sv =====
// Frame parser state machine: sync, header, payload, check word, CRC.
`default_nettype none

module sfp_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  wire logic [7:0]   rx_byte,
	input  wire sfp_pkg::cfg_t cfg,
	output logic              res_valid,
	output sfp_pkg::res_t     res
);
	import sfp_pkg::*;

	localparam logic [3:0] PH_SYNC1   = 4'd0;
	localparam logic [3:0] PH_SYNC2   = 4'd1;
	localparam logic [3:0] PH_ID_LO   = 4'd2;
	localparam logic [3:0] PH_ID_HI   = 4'd3;
	localparam logic [3:0] PH_LEN_LO  = 4'd4;
	localparam logic [3:0] PH_LEN_HI  = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CHK0    = 4'd7;
	localparam logic [3:0] PH_CHK1    = 4'd8;
	localparam logic [3:0] PH_CHK2    = 4'd9;
	localparam logic [3:0] PH_CHK3    = 4'd10;

	logic [3:0]  phase_q, phase_d;
	logic [31:0] crc_q, crc_d;
	logic [7:0]  id_lo_q, id_lo_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] len_q, len_d;
	logic [15:0] cnt_q, cnt_d;
	logic [23:0] chk_q, chk_d;
	logic [31:0] bad_q, bad_d;

	logic [31:0] crc_upd;
	logic [15:0] len_new;
	logic [15:0] cnt_inc;
	logic [31:0] bad_inc;
	logic [31:0] chk_word;

	assign crc_upd  = crc_byte(crc_q, rx_byte);
	assign len_new  = {rx_byte, len_lo_q};
	assign cnt_inc  = cnt_q + 16'd1;
	assign bad_inc  = bad_q + 32'd1;
	assign chk_word = {rx_byte, chk_q};

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		id_lo_d   = id_lo_q;
		id_d      = id_q;
		len_lo_d  = len_lo_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		chk_d     = chk_q;
		bad_d     = bad_q;
		res_valid = 1'b0;
		res.kind          = KIND_PAYLOAD;
		res.bad_frames    = bad_q;
		res.frame_length  = len_q;
		res.frame_id      = id_q;
		res.payload_index = cnt_q;
		res.payload_byte  = rx_byte;
		case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == cfg.sync_second) begin
					crc_d   = crc_upd;
					phase_d = PH_ID_LO;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_ID_LO: begin
				id_lo_d = rx_byte;
				crc_d   = crc_upd;
				phase_d = PH_ID_HI;
			end
			PH_ID_HI: begin
				id_d    = {rx_byte, id_lo_q};
				crc_d   = crc_upd;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_lo_d = rx_byte;
				crc_d    = crc_upd;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = len_new;
				crc_d = crc_upd;
				if (len_new != 16'd0 && len_new <= cfg.max_length) begin
					cnt_d   = 16'd0;
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_PAYLOAD: begin
				crc_d     = crc_upd;
				res_valid = step;
				cnt_d     = cnt_inc;
				if (cnt_inc == len_q) phase_d = PH_CHK0;
			end
			PH_CHK0: begin
				chk_d   = {16'd0, rx_byte};
				phase_d = PH_CHK1;
			end
			PH_CHK1: begin
				chk_d   = {8'd0, rx_byte, chk_q[7:0]};
				phase_d = PH_CHK2;
			end
			PH_CHK2: begin
				chk_d   = {rx_byte, chk_q[15:0]};
				phase_d = PH_CHK3;
			end
			PH_CHK3: begin
				res_valid         = step;
				res.payload_byte  = 8'd0;
				res.payload_index = 16'd0;
				if (chk_word == crc_q) begin
					res.kind = KIND_PASS;
				end else begin
					bad_d          = bad_inc;
					res.kind       = KIND_FAIL;
					res.bad_frames = bad_inc;
				end
				phase_d = PH_SYNC1;
			end
			default: begin
				// first sync, and any unused code
				phase_d = PH_SYNC1;
				if (rx_byte == cfg.sync_first) begin
					crc_d   = crc_byte(cfg.crc_seed, rx_byte);
					phase_d = PH_SYNC2;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			crc_q    <= 32'd1;
			id_lo_q  <= 8'd0;
			id_q     <= 16'd0;
			len_lo_q <= 8'd0;
			len_q    <= 16'd0;
			cnt_q    <= 16'd0;
			chk_q    <= 24'd0;
			bad_q    <= 32'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			id_lo_q  <= id_lo_d;
			id_q     <= id_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			chk_q    <= chk_d;
			bad_q    <= bad_d;
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMPL(a_check_only_at_end, clk, arst_n, res_valid && res.kind != KIND_PAYLOAD, phase_q == PH_CHK3)
	`ASSERT_NEXT(a_end_resyncs, clk, arst_n, step && phase_q == PH_CHK3, phase_q == PH_SYNC1)
	`ASSERT_NEXT(a_fail_counts, clk, arst_n, res_valid && res.kind == KIND_FAIL, bad_q == $past(bad_q) + 32'd1)
	`ASSERT_IMPL(a_payload_in_range, clk, arst_n, phase_q == PH_PAYLOAD, cnt_q < len_q)

endmodule

`default_nettype wire

// ===== src/sfp_skid.sv =====
// Output register with one skid entry, decoupling parser from a stalled sink.
`default_nettype none

module sfp_skid (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire sfp_pkg::res_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	output sfp_pkg::res_t      out_data,
	input  wire logic          out_ready
);
	import sfp_pkg::*;

	logic main_valid_q, skid_valid_q;
	res_t main_q, skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !main_valid_q) begin
			if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !main_valid_q) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_data;
		end
	end

`include "assert_macros.svh"

	`ASSERT_IMPL(a_skid_behind_main, clk, arst_n, skid_valid_q, main_valid_q)
	`ASSERT_IMPL(a_skid_on_stall, clk, arst_n, $rose(skid_valid_q), $past(main_valid_q && !out_ready))
	`ASSERT_NEXT(a_drain_skid, clk, arst_n, skid_valid_q && out_ready, !skid_valid_q && main_valid_q)

endmodule

`default_nettype wire

// ===== src/sensor_frame_parser_crc32.sv =====
// Top level of the sync/length framed packet parser with CRC-32 check.
//
// Slave stream: one received byte per beat in s_tdata[7:0].
// Master stream: one result per payload byte (tuser kind payload) and one per
// frame after the check word (tuser kind pass or fail). Header, sync and check
// bytes produce no beat. Frames are: two sync bytes, id (LE16), length (LE16),
// payload, check word (LE32). A reflected CRC-32 seeded from crc_seed covers
// everything before the check word, no final inversion.
// Output: a result beat is registered (output register, or skid entry on a stall) before m_tvalid.
// Throughput: one byte per cycle while s_tready is high; the per-byte CRC update (eight bit steps)
// and the phase decode sit between the parser state and the output register.
// Stall: a two-entry output (register plus skid) keeps s_tready high until a
// result is parked in the skid entry; s_tready drops only then.
// Reset: parser waits for the first sync byte, CRC state 1, bad-frame count 0,
// output empty, registers back to 0xAA, 0x55, seed 1, max length 9999.
// Config: cfg_we/cfg_index/cfg_wdata, write only while the block is idle.
`default_nettype none

module sensor_frame_parser_crc32 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // payload_byte, payload_index, frame_id,
	                                    // frame_length, bad_frames
	output logic [1:0]       m_tuser,   // kind
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import sfp_pkg::*;

	cfg_t cfg_q;
	logic step;
	logic res_valid;
	res_t res;
	res_t out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
			cfg_q.crc_seed    <= CRC_SEED_RST;
			cfg_q.max_length  <= MAX_LENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_wdata[7:0];
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata[7:0];
				REG_CRC_SEED:    cfg_q.crc_seed    <= cfg_wdata;
				REG_MAX_LENGTH:  cfg_q.max_length  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Parser advances on every accepted byte.
	assign step = s_tvalid && s_tready;

	sfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (s_tdata),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	sfp_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_data   (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_data  (out_res),
		.out_ready (m_tready)
	);

	assign m_tdata = {out_res.bad_frames, out_res.frame_length, out_res.frame_id,
		out_res.payload_index, out_res.payload_byte};
	assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

// ===== test/sfp_result_checker.sv =====
// Result checker for the sensor frame parser: predicts every output beat and compares it.
module sfp_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [87:0] m_tdata,
	input  wire logic [1:0]  m_tuser,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding,
	output int               results_seen,
	output int               pass_seen,
	output int               fail_seen
);
	import sfp_pkg::*;

	typedef enum logic [3:0] {
		WAIT_SYNC1, WAIT_SYNC2, GET_ID_LO, GET_ID_HI, GET_LEN_LO, GET_LEN_HI,
		GET_PAYLOAD, GET_CHK0, GET_CHK1, GET_CHK2, GET_CHK3
	} phase_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [15:0] index;
		logic [15:0] id;
		logic [15:0] length;
		logic [31:0] bad_count;
	} beat_t;

	// predictor copy of registers and parser state
	logic [7:0]  sync1_reg, sync2_reg;
	logic [31:0] seed_reg;
	logic [15:0] max_len_reg;
	phase_e      phase;
	logic [31:0] crc_acc;
	logic [7:0]  id_lo, len_lo;
	logic [15:0] frame_id, frame_len, byte_idx;
	logic [23:0] chk_lo;
	logic [31:0] bad_tally;

	beat_t pending_results[$];

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] acc;
		acc = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++)
			acc = {1'b0, acc[31:1]} ^ (CRC_POLY & {32{acc[0]}});
		return acc;
	endfunction

	task automatic parse_rx_byte(input logic [7:0] b);
		beat_t r;
		r = '0;
		case (phase)
			WAIT_SYNC2: begin
				if (b == sync2_reg) begin
					crc_acc = crc_step(crc_acc, b);
					phase = GET_ID_LO;
				end else
					phase = WAIT_SYNC1;  // this byte is not retried as a first sync
			end
			GET_ID_LO: begin
				id_lo = b;
				crc_acc = crc_step(crc_acc, b);
				phase = GET_ID_HI;
			end
			GET_ID_HI: begin
				frame_id = {b, id_lo};
				crc_acc = crc_step(crc_acc, b);
				phase = GET_LEN_LO;
			end
			GET_LEN_LO: begin
				len_lo = b;
				crc_acc = crc_step(crc_acc, b);
				phase = GET_LEN_HI;
			end
			GET_LEN_HI: begin
				frame_len = {b, len_lo};
				crc_acc = crc_step(crc_acc, b);
				if (frame_len != 16'd0 && frame_len <= max_len_reg) begin
					byte_idx = 16'd0;
					phase = GET_PAYLOAD;
				end else
					phase = WAIT_SYNC1;
			end
			GET_PAYLOAD: begin
				crc_acc = crc_step(crc_acc, b);
				r.kind = KIND_PAYLOAD;
				r.data = b;
				r.index = byte_idx;
				r.id = frame_id;
				r.length = frame_len;
				r.bad_count = bad_tally;
				pending_results.push_back(r);
				byte_idx = byte_idx + 16'd1;
				if (byte_idx == frame_len)
					phase = GET_CHK0;
			end
			GET_CHK0: begin
				chk_lo[7:0] = b;
				phase = GET_CHK1;
			end
			GET_CHK1: begin
				chk_lo[15:8] = b;
				phase = GET_CHK2;
			end
			GET_CHK2: begin
				chk_lo[23:16] = b;
				phase = GET_CHK3;
			end
			GET_CHK3: begin
				if ({b, chk_lo} == crc_acc)
					r.kind = KIND_PASS;
				else begin
					bad_tally = bad_tally + 32'd1;
					r.kind = KIND_FAIL;
				end
				r.id = frame_id;
				r.length = frame_len;
				r.bad_count = bad_tally;
				pending_results.push_back(r);
				phase = WAIT_SYNC1;
			end
			default: begin
				phase = WAIT_SYNC1;
				if (b == sync1_reg) begin
					crc_acc = crc_step(seed_reg, b);
					phase = WAIT_SYNC2;
				end
			end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		beat_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual kind %0d data 0x%0h",
				$time, m_tuser, m_tdata);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		if (want.kind == KIND_PASS)
			pass_seen++;
		else if (want.kind == KIND_FAIL)
			fail_seen++;
		check_field("kind", 32'(want.kind), 32'(m_tuser));
		check_field("payload_byte", 32'(want.data), 32'(m_tdata[7:0]));
		check_field("payload_index", 32'(want.index), 32'(m_tdata[23:8]));
		check_field("frame_id", 32'(want.id), 32'(m_tdata[39:24]));
		check_field("frame_length", 32'(want.length), 32'(m_tdata[55:40]));
		check_field("bad_frames", want.bad_count, m_tdata[87:56]);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			sync1_reg = SYNC_FIRST_RST;
			sync2_reg = SYNC_SECOND_RST;
			seed_reg = CRC_SEED_RST;
			max_len_reg = MAX_LENGTH_RST;
			phase = WAIT_SYNC1;
			crc_acc = 32'd1;
			id_lo = '0;
			len_lo = '0;
			frame_id = '0;
			frame_len = '0;
			byte_idx = '0;
			chk_lo = '0;
			bad_tally = '0;
			pending_results.delete();
			mismatches = 0;
			results_seen = 0;
			pass_seen = 0;
			fail_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SYNC_FIRST:  sync1_reg = cfg_wdata[7:0];
					REG_SYNC_SECOND: sync2_reg = cfg_wdata[7:0];
					REG_CRC_SEED:    seed_reg = cfg_wdata;
					REG_MAX_LENGTH:  max_len_reg = cfg_wdata[15:0];
					default: ;
				endcase
			end
			// a result never leaves on the edge of its own input beat, so push first
			if (s_tvalid && s_tready)
				parse_rx_byte(s_tdata);
			if (m_tvalid && m_tready)
				check_result();
		end
		outstanding = pending_results.size();
	end

endmodule

// ===== test/sensor_frame_parser_crc32_tb.sv =====
// Testbench top for the sensor frame parser: drives byte streams and config, reports the verdict.
module sensor_frame_parser_crc32_tb;
	import sfp_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;    // rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;            // payload_byte, payload_index, frame_id,
	                                 // frame_length, bad_frames
	logic [1:0]  m_tuser;            // kind
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_SYNC_FIRST;
	logic [31:0] cfg_wdata = 32'h0;

	int mismatches, outstanding, results_seen, pass_seen, fail_seen;

	// register values as last written, used to build frames that parse
	logic [7:0]  cur_sync1 = SYNC_FIRST_RST;
	logic [7:0]  cur_sync2 = SYNC_SECOND_RST;
	logic [31:0] cur_seed = CRC_SEED_RST;
	logic [15:0] cur_max = MAX_LENGTH_RST;

	bit idle_on = 1'b1;   // random gaps/stalls on both sides when set
	int bytes_sent = 0;
	int frames_sent = 0;
	int configs_loaded = 1;
	int stall_left = 0;

	always #1 clk = ~clk;

	sensor_frame_parser_crc32 dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	sfp_result_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .outstanding(outstanding), .results_seen(results_seen),
		.pass_seen(pass_seen), .fail_seen(fail_seen)
	);

	// Result side: after each accepted beat, hold tready low for a randomly drawn stall when idle_on is set.
	always @(posedge clk) begin
		int hold;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			hold = idle_on ? $urandom_range(0, 5) : 0;
			stall_left <= hold;
			m_tready <= (hold == 0);
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= (stall_left == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// One byte beat with a random gap ahead of it when idle_on is set. tvalid is only
	// lowered when a gap is drawn, so back-to-back beats keep it high.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Full frame. Zero or oversize lengths stop after the header (parser drops
	// them); 0 <= cut < len truncates the payload and omits the check word.
	task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
			input bit corrupt, input int cut);
		logic [7:0]  hdr [6];
		logic [7:0]  b;
		logic [31:0] crc, mask;
		int n;
		frames_sent++;
		hdr = '{cur_sync1, cur_sync2, id[7:0], id[15:8], len[7:0], len[15:8]};
		crc = cur_seed;
		foreach (hdr[i]) begin
			crc = crc_byte(crc, hdr[i]);
			send_byte(hdr[i]);
		end
		if (len == 16'd0 || len > cur_max)
			return;
		n = (cut >= 0 && cut < int'(len)) ? cut : int'(len);
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom);
			crc = crc_byte(crc, b);
			send_byte(b);
		end
		if (n < int'(len))
			return;
		if (corrupt) begin
			mask = $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
			if (mask == 32'd0)
				mask = 32'd1;
			crc = crc ^ mask;
		end
		for (int i = 0; i < 4; i++)
			send_byte(crc[8*i +: 8]);
	endtask

	function automatic logic [15:0] pick_len();
		int roll, top_len;
		roll = $urandom_range(0, 99);
		if (cur_max == 16'd0)
			return 16'd1;
		if (roll < 5 && cur_max <= 16'd64)
			return cur_max;
		top_len = (roll < 15) ? 32 : 8;
		if (top_len > int'(cur_max))
			top_len = int'(cur_max);
		return 16'($urandom_range(1, top_len));
	endfunction

	// Mostly well-formed frames, plus bad CRCs, bad lengths, broken syncs,
	// truncated frames and plain noise.
	task automatic random_traffic(input int budget);
		int stop_at, roll, n;
		logic [7:0] b;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			idle_on = ($urandom_range(0, 99) >= 15);
			roll = $urandom_range(0, 99);
			if (roll < 55)
				send_frame(16'($urandom), pick_len(), 1'b0, -1);
			else if (roll < 70)
				send_frame(16'($urandom), pick_len(), 1'b1, -1);
			else if (roll < 78) begin
				if (cur_max == 16'hFFFF || $urandom_range(0, 1))
					send_frame(16'($urandom), 16'd0, 1'b0, -1);
				else
					send_frame(16'($urandom), 16'($urandom_range(int'(cur_max) + 1, 65535)),
						1'b0, -1);
			end else if (roll < 84) begin
				// second sync wrong; sometimes a repeated first sync
				send_byte(cur_sync1);
				if (cur_sync1 != cur_sync2 && $urandom_range(0, 1))
					send_byte(cur_sync1);
				else
					send_byte(cur_sync2 ^ 8'($urandom_range(1, 255)));
			end else if (roll < 90) begin
				n = $urandom_range(0, 3);
				send_frame(16'($urandom), pick_len(), 1'b0, n);
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom);
					if (i == n - 1 && b == cur_sync1)
						b = b ^ 8'h01;  // don't leave a dangling first sync
					send_byte(b);
				end
			end
		end
	endtask

	// Stop sending, wait for every expected result, then let the registered
	// parser state settle for bytes that produce no result.
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers back to back; junk in the unused upper bits.
	task automatic load_config(input logic [7:0] s1, input logic [7:0] s2,
			input logic [31:0] seed, input logic [15:0] max_len);
		logic [31:0] junk;
		quiesce();
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_wdata <= {junk[31:8], s1};
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_wdata <= {junk[31:8], s2};
		@(posedge clk);
		cfg_index <= REG_CRC_SEED;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_index <= REG_MAX_LENGTH;
		cfg_wdata <= {junk[31:16], max_len};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_sync1 = s1;
		cur_sync2 = s2;
		cur_seed = seed;
		cur_max = max_len;
		configs_loaded++;
	endtask

	initial begin
		logic [7:0] same_sync;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		send_frame(16'h0000, 16'd1, 1'b0, -1);
		send_frame(16'hFFFF, 16'd2, 1'b0, -1);
		send_frame(16'h00FF, 16'd1, 1'b1, -1);            // CRC mismatch
		send_byte(cur_sync1);                             // doubled first sync loses the frame
		send_frame(16'h1234, 16'd1, 1'b0, -1);
		send_frame(16'h0001, 16'd0, 1'b0, -1);            // zero length
		send_frame(16'h0002, cur_max + 16'd1, 1'b0, -1);  // above max length
		send_frame(16'h8000, 16'd3, 1'b0, -1);
		random_traffic(200);

		// max length 0: every frame dropped
		load_config(SYNC_FIRST_RST, SYNC_SECOND_RST, CRC_SEED_RST, 16'd0);
		random_traffic(40);

		// low extremes
		load_config(8'h00, 8'hFF, 32'h0000_0000, 16'd1);
		random_traffic(200);

		// high extremes, including one 256-byte frame at full rate
		load_config(8'hFF, 8'h00, 32'hFFFF_FFFF, 16'hFFFF);
		random_traffic(200);
		idle_on = 1'b0;
		send_frame(16'($urandom), 16'd256, 1'b0, -1);
		random_traffic(50);

		// identical sync bytes
		same_sync = 8'($urandom);
		load_config(same_sync, same_sync, $urandom, 16'($urandom_range(2, 20)));
		random_traffic(200);

		repeat (2) begin
			load_config(8'($urandom), 8'($urandom), $urandom, 16'($urandom_range(1, 48)));
			random_traffic(80);
		end

		quiesce();
		repeat (8) @(posedge clk);

		$display("Covered %0d input beats, %0d frames, %0d register settings",
			bytes_sent, frames_sent, configs_loaded);
		$display("Checked %0d result beats: %0d frames passed CRC, %0d failed",
			results_seen, pass_seen, fail_seen);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hang guard, well beyond the slowest legal run.
	initial begin
		#400_000;
		$display("%0t: timeout, %0d results still expected", $time, outstanding);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
